@@ hw/rtl/qpht_pkg.sv @@
package qpht_pkg;

  localparam int KEY_W = 31;
  localparam int PAY_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int IDX_W = 10;
  localparam int CNT_W = 10;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

endpackage

@@ hw/rtl/qpht_mod.sv @@
// Home slot: key mod SLOTS by reciprocal multiply, three register stages.
module qpht_mod #(
  parameter int SLOTS = 1021
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qpht_pkg::KEY_W-1:0]  key,
  output logic                        done,
  output logic [$clog2(SLOTS)-1:0]    base
);

  localparam int IW = $clog2(SLOTS);
  localparam int KW = qpht_pkg::KEY_W;
  // floor(2^KW / SLOTS): estimate is exact or one short
  localparam logic [KW-1:0] RECIP = KW'((64'd1 << KW) / SLOTS);
  localparam logic [31:0]   SLOTS_W = 32'(SLOTS);

  logic [2:0]        vld;
  logic [KW-1:0]     key1;
  logic [KW-1:0]     key2;
  logic [2*KW-1:0]   prod;
  logic [31:0]       qs;
  logic [31:0]       rem;
  logic [31:0]       rem_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    key1 <= key;
    prod <= key * RECIP;
    key2 <= key1;
    qs   <= 32'(prod[2*KW-1:KW]) * SLOTS_W;
    base <= IW'(rem_fix);
  end

  always_comb begin
    rem     = {1'b0, key2} - qs;
    rem_fix = (rem >= SLOTS_W) ? rem - SLOTS_W : rem;
  end

  assign done = vld[2];

endmodule

@@ hw/rtl/quadratic_probe_hash_table.sv @@
// Open-addressing hash table with quadratic probing over SLOTS entries.
// Input channel s_*: one operation per transfer, opcode on s_tuser
// (insert, search, delete; the unused code searches), key and data word
// on s_tdata. Output channel m_*: one result per operation, status on
// m_tuser, slot index, found data word and slots examined on m_tdata.
// Timing: after an input transfer the home slot is computed by reciprocal
// multiply, then the probe loop reads one entry per cycle from the single
// table memory through a registered read port. On a miss or a full table
// all SLOTS slots are examined. The next input is taken only after the
// result of the previous one has moved into the output register. Results
// sit in an output register; a stalled receiver holds the next finished
// result back and so also holds off the next input.
// Reset: the table memory is swept to empty, one entry per cycle;
// s_tready stays low until the sweep ends.
module quadratic_probe_hash_table #(
  parameter int SLOTS = 1021
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key[30:0], payload_in[62:31], zero[63]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // slot_index[9:0], payload_out[41:10],
                                 // probe_count[51:42], zero[55:52]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = qpht_pkg::KEY_W;
  localparam int PW = qpht_pkg::PAY_W;
  localparam logic [IW:0]   SLOTS_X = (IW + 1)'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  // probe i -> i+1 moves by 18 + 22i (mod SLOTS)
  localparam logic [IW-1:0] FIRST_STEP = IW'(18 % SLOTS);
  localparam logic [IW-1:0] STEP_INC = IW'(22 % SLOTS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [IW-1:0] clr_addr;

  logic [qpht_pkg::OP_W-1:0] op_r;
  logic [KW-1:0] key_r;
  logic [PW-1:0] pay_r;

  logic          mod_done;
  logic [IW-1:0] mod_base;

  logic [IW-1:0] pos;
  logic [IW-1:0] dlt;
  logic [CW-1:0] cnt;
  logic          rd_live;
  logic [IW-1:0] rd_pos;
  logic [CW-1:0] rd_cnt;

  logic [IW:0]   pos_sum;
  logic [IW:0]   dlt_sum;
  logic [IW-1:0] pos_next;
  logic [IW-1:0] dlt_next;

  qpht_pkg::entry_t mem [SLOTS];
  qpht_pkg::entry_t rdata;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  qpht_pkg::entry_t mem_wdata;

  logic hit;
  logic last;

  logic [qpht_pkg::ST_W-1:0]  res_status;
  logic [qpht_pkg::IDX_W-1:0] res_slot;
  logic [PW-1:0]              res_pay;
  logic [qpht_pkg::CNT_W-1:0] res_cnt;

  logic in_xfer;
  logic out_free;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  qpht_mod #(
    .SLOTS(SLOTS)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(in_xfer),
    .key  (s_tdata[KW-1:0]),
    .done (mod_done),
    .base (mod_base)
  );

  always_comb begin
    pos_sum  = {1'b0, pos} + {1'b0, dlt};
    dlt_sum  = {1'b0, dlt} + {1'b0, STEP_INC};
    pos_next = (pos_sum >= SLOTS_X) ? IW'(pos_sum - SLOTS_X) : IW'(pos_sum);
    dlt_next = (dlt_sum >= SLOTS_X) ? IW'(dlt_sum - SLOTS_X) : IW'(dlt_sum);
  end

  always_comb begin
    case (op_r) inside
      qpht_pkg::OP_INSERT: hit = !rdata.valid;
      qpht_pkg::OP_SEARCH,
      qpht_pkg::OP_DELETE: hit = rdata.valid && (rdata.key == key_r);
      default:             hit = rdata.valid && (rdata.key == key_r);
    endcase
    last = (rd_cnt == SLOTS_C);
  end

  // table write: sweep after reset, insert fill or delete clear on a hit
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_pos;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (state == S_PROBE && rd_live && hit) begin
      if (op_r == qpht_pkg::OP_INSERT) begin
        mem_we            = 1'b1;
        mem_wdata.valid   = 1'b1;
        mem_wdata.key     = key_r;
        mem_wdata.payload = pay_r;
      end else if (op_r == qpht_pkg::OP_DELETE) begin
        mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_live  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          rd_live <= 1'b0;
          if (mod_done) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (rd_live && (hit || last)) begin
            rd_live <= 1'b0;
            state   <= S_DONE;
          end else begin
            rd_live <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // operation context, probe walk and result capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= s_tuser;
      key_r <= s_tdata[KW-1:0];
      pay_r <= s_tdata[KW+PW-1:KW];
    end
    if (state == S_MOD) begin
      pos <= mod_base;
      dlt <= FIRST_STEP;
      cnt <= CW'(1);
    end else if (state == S_PROBE) begin
      pos    <= pos_next;
      dlt    <= dlt_next;
      cnt    <= cnt + 1'b1;
      rd_pos <= pos;
      rd_cnt <= cnt;
    end
    if (state == S_PROBE && rd_live) begin
      if (hit) begin
        res_status <= qpht_pkg::ST_OK;
        res_slot   <= qpht_pkg::IDX_W'(rd_pos);
        res_cnt    <= qpht_pkg::CNT_W'(rd_cnt);
        res_pay    <= (op_r == qpht_pkg::OP_INSERT || op_r == qpht_pkg::OP_DELETE) ?
                      '0 : rdata.payload;
      end else if (last) begin
        res_status <= (op_r == qpht_pkg::OP_INSERT) ?
                      qpht_pkg::ST_FULL : qpht_pkg::ST_MISS;
        res_slot   <= '0;
        res_cnt    <= qpht_pkg::CNT_W'(SLOTS_C);
        res_pay    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {4'd0, res_cnt, res_pay, res_slot};
    end
  end

`ifndef NO_ASSERTIONS
  a_write_qual: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR) || (state == S_PROBE && rd_live))
    else $error("table write outside sweep or probe check");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && rd_live) |-> ({1'b0, rd_pos} < SLOTS_X) &&
      (rd_cnt != '0) && (rd_cnt <= SLOTS_C))
    else $error("probe slot or count out of range");

  a_start_mod: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_MOD) ##2 mod_done)
    else $error("home slot not ready three cycles after transfer");
`endif

endmodule

@@ tb/qpht_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels of the hash table, keeps a shadow copy of the
// slot table and compares each result transfer with the oldest prediction.
module qpht_checker #(
  parameter int SLOTS = 1021
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          n_pending,
  output int          n_errors,
  output int          n_ok,
  output int          n_missed,
  output int          n_overflow
);

  typedef struct packed {
    logic [qpht_pkg::ST_W-1:0]  status;
    logic [qpht_pkg::IDX_W-1:0] slot;
    logic [qpht_pkg::PAY_W-1:0] payload;
    logic [qpht_pkg::CNT_W-1:0] probes;
  } hash_result_t;

  bit                         shadow_valid   [SLOTS];
  logic [qpht_pkg::KEY_W-1:0] shadow_key     [SLOTS];
  logic [qpht_pkg::PAY_W-1:0] shadow_payload [SLOTS];

  hash_result_t awaited_results[$];

  // slot visited by probe number i: (key mod SLOTS + 7i + 11i^2) mod SLOTS
  function automatic int unsigned chain_slot(logic [qpht_pkg::KEY_W-1:0] k,
                                             int unsigned i);
    longint unsigned home;
    longint unsigned ii;
    home = longint'(k) % longint'(SLOTS);
    ii   = longint'(i);
    return int'((home + 7 * ii + 11 * ii * ii) % longint'(SLOTS));
  endfunction

  // Applies one operation to the shadow table and returns its result.
  function automatic hash_result_t probe_and_update(logic [qpht_pkg::OP_W-1:0] op,
                                                    logic [qpht_pkg::KEY_W-1:0] k,
                                                    logic [qpht_pkg::PAY_W-1:0] p);
    hash_result_t r;
    int unsigned  i;
    int unsigned  j;
    bit           done;
    r.status  = qpht_pkg::ST_MISS;
    r.slot    = '0;
    r.payload = '0;
    r.probes  = qpht_pkg::CNT_W'(SLOTS);
    done      = 1'b0;
    if (op == qpht_pkg::OP_INSERT) begin
      r.status = qpht_pkg::ST_FULL;
      for (i = 0; i < SLOTS && !done; i++) begin
        j = chain_slot(k, i);
        if (!shadow_valid[j]) begin
          shadow_valid[j]   = 1'b1;
          shadow_key[j]     = k;
          shadow_payload[j] = p;
          r.status = qpht_pkg::ST_OK;
          r.slot   = qpht_pkg::IDX_W'(j);
          r.probes = qpht_pkg::CNT_W'(i + 1);
          done     = 1'b1;
        end
      end
    end else begin
      // search, delete and the spare code walk the chain up to a matching key, not stopping at empty slots
      for (i = 0; i < SLOTS && !done; i++) begin
        j = chain_slot(k, i);
        if (shadow_valid[j] && shadow_key[j] == k) begin
          r.status = qpht_pkg::ST_OK;
          r.slot   = qpht_pkg::IDX_W'(j);
          r.probes = qpht_pkg::CNT_W'(i + 1);
          if (op == qpht_pkg::OP_DELETE) shadow_valid[j] = 1'b0;
          else r.payload = shadow_payload[j];
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    hash_result_t got;
    hash_result_t want;
    if (rst) begin
      awaited_results.delete();
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      n_pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status  = m_tuser;
        got.slot    = m_tdata[9:0];
        got.payload = m_tdata[41:10];
        got.probes  = m_tdata[51:42];
        if (awaited_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          n_errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("slot_index", want.slot, got.slot);
          check_field("payload_out", want.payload, got.payload);
          check_field("probe_count", want.probes, got.probes);
        end
      end
      if (s_tvalid && s_tready) begin
        want = probe_and_update(s_tuser, s_tdata[30:0], s_tdata[62:31]);
        awaited_results.push_back(want);
        case (want.status)
          qpht_pkg::ST_OK:   n_ok++;
          qpht_pkg::ST_MISS: n_missed++;
          default:           n_overflow++;
        endcase
      end
      n_pending <= awaited_results.size();
    end
  end

endmodule

@@ tb/tb_quadratic_probe_hash_table.sv @@
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;

  localparam int SLOTS       = 1021;
  localparam int RANDOM_OPS  = 270;
  localparam int CHAIN_FILL  = 530;
  localparam int QUIET_LIMIT = 10000;
  // unused opcode, handled as a search
  localparam logic [qpht_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = qpht_pkg::OP_SEARCH;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  int chk_pending;
  int chk_errors;
  int chk_ok;
  int chk_missed;
  int chk_overflow;

  int n_inserts = 0;
  int n_searches = 0;
  int n_deletes = 0;
  int n_spare = 0;

  bit tx_burst = 1'b0;
  int rx_hold = 0;

  logic [qpht_pkg::KEY_W-1:0] live_keys[$];
  logic [qpht_pkg::KEY_W-1:0] chain_keys[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quadratic_probe_hash_table #(.SLOTS(SLOTS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  qpht_checker #(.SLOTS(SLOTS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .n_pending  (chk_pending),
    .n_errors   (chk_errors),
    .n_ok       (chk_ok),
    .n_missed   (chk_missed),
    .n_overflow (chk_overflow)
  );

  // receiver back-pressure: short and long ready runs, mostly short stalls, a few long
  always @(posedge clk) begin
    int r;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        m_tready <= 1'b1;
        rx_hold  <= $urandom_range(0, 7);
      end else if (r < 55) begin
        m_tready <= 1'b1;
        rx_hold  <= $urandom_range(40, 150);
      end else if (r < 85) begin
        m_tready <= 1'b0;
        rx_hold  <= $urandom_range(0, 2);
      end else if (r < 96) begin
        m_tready <= 1'b0;
        rx_hold  <= $urandom_range(3, 11);
      end else begin
        m_tready <= 1'b0;
        rx_hold  <= $urandom_range(20, 60);
      end
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_op(input logic [qpht_pkg::OP_W-1:0] op,
                         input logic [qpht_pkg::KEY_W-1:0] k,
                         input logic [qpht_pkg::PAY_W-1:0] p);
    int gap;
    gap = tx_burst ? 0 : idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, p, k};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (op)
      qpht_pkg::OP_INSERT: n_inserts++;
      qpht_pkg::OP_SEARCH: n_searches++;
      qpht_pkg::OP_DELETE: n_deletes++;
      default:             n_spare++;
    endcase
  endtask

  // hold the input off until every outstanding result has been handed over
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
  endtask

  function automatic logic [qpht_pkg::KEY_W-1:0] take_live_key();
    int idx;
    logic [qpht_pkg::KEY_W-1:0] k;
    idx = $urandom_range(0, live_keys.size() - 1);
    k = live_keys[idx];
    live_keys.delete(idx);
    return k;
  endfunction

  function automatic logic [qpht_pkg::KEY_W-1:0] fresh_key();
    if ($urandom_range(0, 9) < 3) return qpht_pkg::KEY_W'($urandom_range(0, 4 * SLOTS));
    return qpht_pkg::KEY_W'($urandom());
  endfunction

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int pick;
    int unsigned home;
    logic [qpht_pkg::KEY_W-1:0] k;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, key and data extremes, collisions, duplicates
    send_op(qpht_pkg::OP_SEARCH, '0, $urandom());
    send_op(qpht_pkg::OP_DELETE, '1, $urandom());
    send_op(qpht_pkg::OP_INSERT, '0, '0);
    send_op(qpht_pkg::OP_INSERT, '1, '1);
    send_op(qpht_pkg::OP_SEARCH, '0, $urandom());
    send_op(qpht_pkg::OP_SEARCH, '1, $urandom());
    send_op(qpht_pkg::OP_INSERT, '0, 32'hA5A5_5A5A);
    send_op(qpht_pkg::OP_SEARCH, '0, '1);
    send_op(qpht_pkg::OP_INSERT, qpht_pkg::KEY_W'(SLOTS), $urandom());
    send_op(qpht_pkg::OP_SEARCH, qpht_pkg::KEY_W'(SLOTS), $urandom());
    send_op(OP_SPARE, '1, '1);
    send_op(OP_SPARE, 31'h1234_5678, '0);
    send_op(qpht_pkg::OP_DELETE, '0, $urandom());
    send_op(qpht_pkg::OP_SEARCH, '0, $urandom());
    send_op(qpht_pkg::OP_SEARCH, qpht_pkg::KEY_W'(SLOTS), $urandom());
    send_op(qpht_pkg::OP_DELETE, '0, $urandom());
    send_op(qpht_pkg::OP_DELETE, '0, $urandom());
    send_op(qpht_pkg::OP_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
    send_op(qpht_pkg::OP_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
    send_op(qpht_pkg::OP_DELETE, '1, $urandom());
    send_op(qpht_pkg::OP_DELETE, qpht_pkg::KEY_W'(SLOTS), $urandom());
    send_op(qpht_pkg::OP_SEARCH, 31'h5555_5555, $urandom());
    live_keys.push_back(31'h2AAA_AAAA);
    live_keys.push_back(31'h5555_5555);

    wait_results_drained();

    // random mix, mostly operations on keys known to be stored
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (live_keys.size() == 0 && ((pick >= 35 && pick < 85) || pick >= 96)) pick = 0;
      if (live_keys.size() > 120 && pick < 35) pick = 70;
      if (pick < 35) begin
        if (live_keys.size() > 0 && $urandom_range(0, 9) == 0)
          k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else
          k = fresh_key();
        live_keys.push_back(k);
        send_op(qpht_pkg::OP_INSERT, k, $urandom());
      end else if (pick < 65) begin
        send_op(qpht_pkg::OP_SEARCH, live_keys[$urandom_range(0, live_keys.size() - 1)],
                $urandom());
      end else if (pick < 85) begin
        send_op(qpht_pkg::OP_DELETE, take_live_key(), $urandom());
      end else if (pick < 93) begin
        send_op(qpht_pkg::OP_SEARCH, fresh_key(), $urandom());
      end else if (pick < 96) begin
        send_op(qpht_pkg::OP_DELETE, fresh_key(), $urandom());
      end else begin
        send_op(OP_SPARE, live_keys[$urandom_range(0, live_keys.size() - 1)], $urandom());
      end
    end
    tx_burst = 1'b0;

    // every key on one home slot: fills its probe chain until inserts overflow
    home = $urandom_range(0, SLOTS - 1);
    for (int n = 0; n < CHAIN_FILL; n++) begin
      k = qpht_pkg::KEY_W'(home + SLOTS * $urandom_range(0, 2000000));
      chain_keys.push_back(k);
      send_op(qpht_pkg::OP_INSERT, k, $urandom());
    end
    for (int n = 0; n < 5; n++) send_op(qpht_pkg::OP_SEARCH, chain_keys[n], $urandom());
    for (int n = 0; n < 3; n++) send_op(qpht_pkg::OP_DELETE, chain_keys[n], $urandom());
    send_op(qpht_pkg::OP_SEARCH, chain_keys[1], $urandom());
    send_op(qpht_pkg::OP_SEARCH, qpht_pkg::KEY_W'(home + SLOTS * 2100000), $urandom());
    send_op(OP_SPARE, chain_keys[5], $urandom());
    send_op(qpht_pkg::OP_INSERT, qpht_pkg::KEY_W'(home), $urandom());
    send_op(qpht_pkg::OP_INSERT, qpht_pkg::KEY_W'(home + SLOTS), $urandom());

    wait_results_drained();
    repeat (32) @(posedge clk);

    $display("Ran %0d inserts, %0d searches, %0d deletes, %0d spare-code ops",
             n_inserts, n_searches, n_deletes, n_spare);
    $display("Outcomes: %0d ok, %0d key missing, %0d table full",
             chk_ok, chk_missed, chk_overflow);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
